[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

[rtl/bpci_pkg.sv]
// Package: curve tables, widths and pipeline constants of the battery level lookup.
package bpci_pkg;

    // Curve points in use; entries from this index on are ignored by the search.
    localparam int CURVE_POINTS = 12;
    localparam int TABLE_SLOTS  = 16;
    localparam int PTS          = (CURVE_POINTS > TABLE_SLOTS) ? TABLE_SLOTS : CURVE_POINTS;
    localparam int IDX_W        = $clog2(TABLE_SLOTS);

    // Field and datapath widths
    localparam int RAW_W  = 16;
    localparam int MV_W   = 16;
    localparam int PCT_W  = 8;
    localparam int LVL_W  = 7;
    // Voltage step between neighbor points fits here (largest step is 1585 mV)
    localparam int VD_W   = 11;
    localparam int PROD_W = VD_W + PCT_W;
    // Quotient bits: the share is always below the percent gap
    localparam int QW     = PCT_W;
    // Edges from the accepting edge to the edge that takes the result
    localparam int PIPE_LAT = QW + 4;

    localparam logic [MV_W-1:0]  OFFSET_MV   = MV_W'(16'h0096);
    localparam logic [MV_W-1:0]  FLOOR_MV    = MV_W'(1515);
    localparam logic [PCT_W:0]   CAP_PERCENT = (PCT_W+1)'(100);
    localparam logic [PCT_W-1:0] MIN_PERCENT = PCT_W'(1);

    // Curve: descending voltages and their percents, padded to full depth
    localparam logic [MV_W-1:0] MV_TAB [TABLE_SLOTS] = '{
        16'd4150, 16'd4050, 16'd3920, 16'd3850, 16'd3750, 16'd3680, 16'd3640, 16'd3600,
        16'd3570, 16'd3500, 16'd3100, 16'd1515, 16'd0, 16'd0, 16'd0, 16'd0
    };

    localparam logic [PCT_W-1:0] PCT_TAB [TABLE_SLOTS] = '{
        8'd100, 8'd90, 8'd80, 8'd70, 8'd60, 8'd50, 8'd40, 8'd30,
        8'd20, 8'd10, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1
    };

endpackage

[rtl/battery_percent_curve_interp_core.sv]
// Battery charge level from one ADC reading by piecewise-linear curve lookup.
// Throughput: one reading per cycle; busy is never raised and start is taken every cycle.
// Pipeline: o_done carries the result after these registered stages, in order:
//   millivolt form, curve search, step select and multiply, 8 one-bit divide stages, cap.
// The result strobe lasts one cycle; the receiver cannot stall, so no skid storage.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; items in flight are dropped.
module battery_percent_curve_interp_core import bpci_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic signed [RAW_W-1:0] i_raw_sample,
    output logic                    busy,
    output logic                    o_done,
    output logic        [LVL_W-1:0] o_level_percent
);

    logic accept;

    // Stage A: millivolt value
    logic            r_a_vld;
    logic [MV_W-1:0] r_a_mv;
    logic [MV_W-1:0] n_a_mv;

    // Stage B: curve search
    logic             r_b_vld;
    logic [MV_W-1:0]  r_b_mv;
    logic [IDX_W-1:0] r_b_idx;
    logic             r_b_one;
    logic [IDX_W-1:0] n_b_idx;
    logic             n_b_found;
    logic             n_b_one;

    // Stage C: segment select and multiply
    logic [IDX_W-1:0]  c_up;
    logic [MV_W-1:0]   c_lo;
    logic [MV_W-1:0]   c_hi;
    logic [PCT_W-1:0]  c_pct;
    logic [PCT_W-1:0]  c_phi;
    logic              n_c_interp;
    logic [VD_W-1:0]   n_c_vdiff;
    logic [VD_W-1:0]   n_c_span;
    logic [PCT_W-1:0]  n_c_gap;
    logic [PCT_W-1:0]  n_c_base;
    logic [PROD_W-1:0] n_c_prod;

    // Divide stages; entry 0 is the multiply register
    logic              r_d_vld    [QW+1];
    logic [PROD_W-1:0] r_d_rem    [QW+1];
    logic [QW-1:0]     r_d_q      [QW+1];
    logic [VD_W-1:0]   r_d_span   [QW+1];
    logic [PCT_W-1:0]  r_d_gap    [QW+1];
    logic [PCT_W-1:0]  r_d_base   [QW+1];
    logic              r_d_interp [QW+1];
    logic              n_d_ge     [QW];
    logic [PROD_W-1:0] n_d_trial  [QW];

    // Final stage: clamp, add, cap
    logic [PCT_W-1:0] f_add;
    logic [PCT_W:0]   f_sum;
    logic [LVL_W-1:0] n_out_lvl;
    logic             r_out_vld;
    logic [LVL_W-1:0] r_out_lvl;

    // No back-pressure anywhere: a new reading is taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Millivolts: 2*raw + offset, wrapped to 16 bits
    assign n_a_mv = {i_raw_sample[RAW_W-2:0], 1'b0} + OFFSET_MV;

    // First point from the top whose voltage is not above the value
    always_comb begin
        n_b_idx   = '0;
        n_b_found = 1'b0;
        for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
            if (k < PTS && MV_TAB[k] <= r_a_mv) begin
                n_b_idx   = IDX_W'(k);
                n_b_found = 1'b1;
            end
        end
        n_b_one = (r_a_mv <= FLOOR_MV) || !n_b_found;
    end

    // Segment bounds, share numerator and divisor
    always_comb begin
        c_up       = r_b_idx - IDX_W'(1);
        c_lo       = MV_TAB[r_b_idx];
        c_hi       = MV_TAB[c_up];
        c_pct      = PCT_TAB[r_b_idx];
        c_phi      = PCT_TAB[c_up];
        n_c_interp = !r_b_one && (r_b_idx != '0) && (r_b_mv != c_lo) &&
                     (c_hi > c_lo) && (c_phi >= c_pct);
        n_c_vdiff  = VD_W'(r_b_mv - c_lo);
        n_c_span   = VD_W'(c_hi - c_lo);
        n_c_gap    = c_phi - c_pct;
        n_c_base   = r_b_one ? MIN_PERCENT : c_pct;
        n_c_prod   = PROD_W'(n_c_vdiff) * PROD_W'(n_c_gap);
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int B = QW - 1 - s;

        assign n_d_trial[s] = PROD_W'(r_d_span[s]) << B;
        assign n_d_ge[s]    = r_d_rem[s] >= n_d_trial[s];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[s+1] <= 1'b0;
            end else begin
                r_d_vld[s+1] <= r_d_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_rem[s+1]    <= n_d_ge[s] ? (r_d_rem[s] - n_d_trial[s]) : r_d_rem[s];
            r_d_q[s+1]      <= r_d_q[s] | (QW'(n_d_ge[s]) << B);
            r_d_span[s+1]   <= r_d_span[s];
            r_d_gap[s+1]    <= r_d_gap[s];
            r_d_base[s+1]   <= r_d_base[s];
            r_d_interp[s+1] <= r_d_interp[s];
        end
    end

    // Share clamped to the gap, result capped at 100
    always_comb begin
        f_add = '0;
        if (r_d_interp[QW]) begin
            f_add = (r_d_q[QW] > r_d_gap[QW]) ? r_d_gap[QW] : r_d_q[QW];
        end
        f_sum     = {1'b0, r_d_base[QW]} + {1'b0, f_add};
        n_out_lvl = (f_sum > CAP_PERCENT) ? LVL_W'(CAP_PERCENT) : LVL_W'(f_sum);
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_d_vld[0] <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_a_vld    <= accept;
            r_b_vld    <= r_a_vld;
            r_d_vld[0] <= r_b_vld;
            r_out_vld  <= r_d_vld[QW];
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        r_a_mv        <= n_a_mv;
        r_b_mv        <= r_a_mv;
        r_b_idx       <= n_b_idx;
        r_b_one       <= n_b_one;
        r_d_rem[0]    <= n_c_prod;
        r_d_q[0]      <= '0;
        r_d_span[0]   <= n_c_span;
        r_d_gap[0]    <= n_c_gap;
        r_d_base[0]   <= n_c_base;
        r_d_interp[0] <= n_c_interp;
        r_out_lvl     <= n_out_lvl;
    end

    assign o_done          = r_out_vld;
    assign o_level_percent = r_out_lvl;

endmodule

[rtl/bpci_checker.sv]
// Port-level checker of the battery level lookup, bound to the top level.
`include "assert_macros.svh"

module bpci_checker import bpci_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic signed [RAW_W-1:0] i_raw_sample,
    input logic                    busy,
    input logic                    o_done,
    input logic        [LVL_W-1:0] o_level_percent
);

    logic in_xfer;
    logic lvl_ok;

    assign in_xfer = start && !busy && (i_raw_sample == i_raw_sample);

    // Legal charge level: 1 to 100 percent
    assign lvl_ok = (o_level_percent >= LVL_W'(1)) && (o_level_percent <= LVL_W'(100));

    // The pipeline never pushes back
    `ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy, "busy raised")

    // Every input transfer yields its result a fixed latency later
    `ASSERT_PROP(a_in_to_out, i_clk, i_rst_n, in_xfer |-> ##PIPE_LAT o_done, "result missing")

    // No result without an input transfer at the matching earlier edge
    `ASSERT_PROP(a_out_from_in, i_clk, i_rst_n, o_done |-> $past(start, PIPE_LAT), "spurious result")

    // Results stay within 1 to 100 percent
    `ASSERT_PROP(a_out_range, i_clk, i_rst_n, o_done |-> lvl_ok, "level out of range")

endmodule

bind battery_percent_curve_interp_core bpci_checker u_bpci_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .i_raw_sample    (i_raw_sample),
    .busy            (busy),
    .o_done          (o_done),
    .o_level_percent (o_level_percent)
);
